### rtl/wcst_pkg.sv
package wcst_pkg;

  localparam int MaxBlobs = 16;
  localparam int CntW = $clog2(MaxBlobs + 1);
  localparam int AddrW = 4;

  localparam logic [AddrW-1:0] AddrRate = 4'h0;
  localparam logic [AddrW-1:0] AddrGain = 4'h4;
  localparam logic [AddrW-1:0] AddrDamp = 4'h8;

  localparam logic [15:0] RateReset = 16'd3932;
  localparam logic [15:0] GainReset = 16'd2560;
  localparam logic [15:0] DampReset = 16'd45875;
  localparam logic [31:0] DsqMin = 32'd7;

  localparam logic signed [20:0] PosMax = 21'sd1048575;
  localparam logic signed [20:0] PosMin = -21'sd1048576;
  localparam logic signed [23:0] VelMax = 24'sd8388607;
  localparam logic signed [23:0] VelMin = -24'sd8388608;

  // one classified item between front and back
  typedef struct packed {
    logic        empty;
    logic        last;
    logic        acc;
    logic [11:0] bx;
    logic [11:0] by;
    logic [32:0] w;
  } wcst_job_t;

  localparam int QDepth = 2;

endpackage

### rtl/wcst_if.sv
interface wcst_in_if;
  logic        valid;
  logic        ready;
  logic        frame_empty;
  logic [11:0] blob_x;
  logic [11:0] blob_y;
  logic [15:0] blob_distance;
  logic        last_blob;
  modport source(output valid, frame_empty, blob_x, blob_y, blob_distance, last_blob,
                 input ready);
  modport sink(input valid, frame_empty, blob_x, blob_y, blob_distance, last_blob,
               output ready);
endinterface

interface wcst_out_if;
  logic               valid;
  logic               ready;
  logic signed [20:0] smoothed_x;
  logic signed [20:0] smoothed_y;
  logic [15:0]        presence;
  modport source(output valid, smoothed_x, smoothed_y, presence, input ready);
  modport sink(input valid, smoothed_x, smoothed_y, presence, output ready);
endinterface

### rtl/wcst_div.sv
// Restoring divider, one quotient bit per cycle.
module wcst_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [63:0] den,
  output logic        busy,
  output logic        done,
  output logic [63:0] quo
);
  logic [63:0] rem;
  logic [63:0] q;
  logic [63:0] d;
  logic [6:0]  cnt;
  logic [64:0] trial;

  assign trial = {rem, q[63]} - {1'b0, d};
  assign quo = q;

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      rem  <= '0;
      q    <= num;
      d    <= den;
      cnt  <= 7'd64;
    end else if (busy) begin
      if (!trial[64]) begin
        rem <= trial[63:0];
        q   <= {q[62:0], 1'b1};
      end else begin
        rem <= {rem[62:0], q[63]};
        q   <= {q[62:0], 1'b0};
      end
      cnt <= cnt - 7'd1;
      if (cnt == 7'd1) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end
endmodule

### rtl/wcst_front.sv
// Accepts items, computes weights with its own divider, pushes jobs.
module wcst_front (
  input  logic clk,
  input  logic rst,
  wcst_in_if.sink in_ch,
  output logic q_push,
  output wcst_pkg::wcst_job_t q_data,
  input  logic q_full
);
  import wcst_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SQ, S_DIV, S_PUSH} st_t;
  st_t st;
  wcst_job_t job;
  logic [CntW-1:0] seen;
  logic [15:0] blob_d;
  logic [31:0] dsq;
  logic div_start, div_busy, div_done;
  logic [63:0] div_q;

  assign in_ch.ready = (st == S_IDLE);
  assign q_data = job;
  assign q_push = (st == S_PUSH) && !q_full;
  assign div_start = (st == S_SQ);
  assign dsq = 32'(blob_d) * 32'(blob_d);

  wcst_div u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .num(64'h1_0000_0000),
    .den({32'd0, (dsq < DsqMin) ? DsqMin : dsq}),
    .busy(div_busy), .done(div_done), .quo(div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= S_IDLE;
      seen <= '0;
    end else begin
      unique case (st)
        S_IDLE: if (in_ch.valid) begin
          job.empty <= in_ch.frame_empty;
          job.last  <= in_ch.last_blob;
          job.bx    <= in_ch.blob_x;
          job.by    <= in_ch.blob_y;
          job.w     <= '0;
          blob_d    <= in_ch.blob_distance;
          if (in_ch.frame_empty) begin
            job.acc <= 1'b0;
            seen    <= '0;
            st      <= S_PUSH;
          end else begin
            job.acc <= (seen < CntW'(MaxBlobs));
            if (in_ch.last_blob) seen <= '0;
            else if (seen < CntW'(MaxBlobs)) seen <= seen + 1'b1;
            st <= (seen < CntW'(MaxBlobs)) ? S_SQ : S_PUSH;
          end
        end
        S_SQ:   st <= S_DIV;
        S_DIV: if (div_done) begin
          job.w <= div_q[32:0];
          st    <= S_PUSH;
        end
        S_PUSH: if (!q_full) st <= S_IDLE;
        default: st <= S_IDLE;
      endcase
    end
  end
endmodule

### rtl/wcst_back.sv
// Accumulates jobs; at frame end divides and runs the spring update, or on an empty frame only decays the presence.
module wcst_back (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  input  wcst_pkg::wcst_job_t q_data,
  output logic q_pop,
  input  logic [15:0] rate,
  input  logic [15:0] gain,
  input  logic [15:0] damp,
  wcst_out_if.source out_ch
);
  import wcst_pkg::*;

  typedef enum logic [3:0] {
    B_IDLE, B_DIVX, B_WX, B_DIVY, B_WY, B_P1, B_P2, B_P3, B_P4, B_P5, B_NEXT, B_OUT
  } st_t;
  st_t st;
  logic [47:0] sum_x, sum_y;
  logic [35:0] wtot;
  logic [15:0] inten;
  logic signed [20:0] trk [2];
  logic signed [23:0] vel [2];
  logic signed [20:0] tgt [2];
  logic ax;
  logic signed [22:0] diff;
  logic signed [39:0] dg;
  logic signed [56:0] push;
  logic signed [40:0] vd;
  logic signed [33:0] vsum;
  logic signed [23:0] vnew;
  logic signed [40:0] vr;
  logic signed [24:0] psum;
  logic div_start, div_busy, div_done;
  logic [63:0] div_q;
  logic [63:0] num;

  assign q_pop = (st == B_IDLE) && q_valid && !out_ch.valid;
  assign num = {8'd0, ((st == B_DIVY || st == B_WY) ? sum_y : sum_x), 8'd0};
  assign div_start = (st == B_DIVX) || (st == B_DIVY);

  wcst_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(num), .den({28'd0, wtot}),
    .busy(div_busy), .done(div_done), .quo(div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= B_IDLE;
      out_ch.valid <= 1'b0;
      sum_x <= '0; sum_y <= '0; wtot <= '0;
      inten <= '0;
      trk[0] <= '0; trk[1] <= '0; vel[0] <= '0; vel[1] <= '0;
      ax <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
      unique case (st)
        B_IDLE: if (q_pop) begin
          if (q_data.empty) begin
            sum_x <= '0; sum_y <= '0; wtot <= '0;
            inten <= inten - 16'((32'(inten) * 32'(rate) + 32'd65535) >> 16);
            st <= B_OUT;
          end else begin
            if (q_data.acc) begin
              sum_x <= sum_x + 48'(q_data.bx) * 48'(q_data.w);
              sum_y <= sum_y + 48'(q_data.by) * 48'(q_data.w);
              wtot  <= wtot + 36'(q_data.w);
            end
            if (q_data.last) st <= B_DIVX;
          end
        end
        B_DIVX: begin
          // intensity rise; cannot exceed 65535 since rate < 1
          inten <= inten + 16'((33'(17'h10000 - 17'(inten)) * 33'(rate)) >> 16);
          st <= B_WX;
        end
        B_WX: if (div_done) begin
          tgt[0] <= (wtot == '0) ? '0 : 21'(div_q);
          st <= B_DIVY;
        end
        B_DIVY: st <= B_WY;
        B_WY: if (div_done) begin
          tgt[1] <= (wtot == '0) ? '0 : 21'(div_q);
          ax <= 1'b0;
          st <= B_P1;
        end
        B_P1: begin
          diff <= 23'(tgt[ax]) - 23'(trk[ax]);
          st <= B_P2;
        end
        B_P2: begin
          dg <= 40'(diff) * $signed({1'b0, gain});
          st <= B_P3;
        end
        B_P3: begin
          push <= 57'(dg) * $signed({1'b0, rate});
          st <= B_P4;
        end
        B_P4: begin
          vd <= 41'(vnew) * $signed({1'b0, damp});
          st <= B_P5;
        end
        B_P5: begin
          vel[ax] <= 24'(vd >>> 16);
          vr <= 41'(24'(vd >>> 16)) * $signed({1'b0, rate});
          st <= B_NEXT;
        end
        B_NEXT: begin
          trk[ax] <= (psum > 25'(PosMax)) ? PosMax :
                     (psum < 25'(PosMin)) ? PosMin : 21'(psum);
          if (ax) begin
            sum_x <= '0; sum_y <= '0; wtot <= '0;
            st <= B_OUT;
          end else begin
            ax <= 1'b1;
            st <= B_P1;
          end
        end
        B_OUT: begin
          out_ch.valid <= 1'b1;
          out_ch.smoothed_x <= trk[0];
          out_ch.smoothed_y <= trk[1];
          out_ch.presence <= inten;
          st <= B_IDLE;
        end
        default: st <= B_IDLE;
      endcase
    end
  end

  always_comb begin
    vsum = 34'(vel[ax]) + 34'(push >>> 24);
    if (vsum > 34'(VelMax)) vnew = VelMax;
    else if (vsum < 34'(VelMin)) vnew = VelMin;
    else vnew = 24'(vsum);
    psum = 25'(trk[ax]) + 25'(vr >>> 16);
  end
endmodule

### rtl/weighted_centroid_spring_tracker.sv
// Front: a blob goes S_IDLE, S_SQ, S_DIV (waits on the weight divider), S_PUSH;
// an empty or overflow item goes from S_IDLE straight to S_PUSH.
// At an end of frame the back stage runs two divides (x and y) and the spring update.
// The front takes one blob at a time; front and back overlap through a 2-entry queue.
// Reset (rst, synchronous): registers to defaults, state and accumulators to zero.
module weighted_centroid_spring_tracker (
  input  logic clk,
  input  logic rst,
  wcst_in_if.sink in_ch,
  wcst_out_if.source out_ch,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [wcst_pkg::AddrW-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  import wcst_pkg::*;

  logic [15:0] rate, gain, damp;
  wcst_job_t q [QDepth];
  wcst_job_t f_data;
  logic f_push, b_pop;
  logic [0:0] wp, rp;
  logic [1:0] cnt;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rate <= RateReset; gain <= GainReset; damp <= DampReset;
    end else if (psel && penable && pwrite) begin
      unique case (paddr)
        AddrRate: rate <= pwdata[15:0];
        AddrGain: gain <= pwdata[15:0];
        AddrDamp: damp <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      AddrRate: prdata = {16'd0, rate};
      AddrGain: prdata = {16'd0, gain};
      AddrDamp: prdata = {16'd0, damp};
      default:  prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      if (f_push) wp <= wp + 1'b1;
      if (b_pop) rp <= rp + 1'b1;
      cnt <= cnt + 2'(f_push) - 2'(b_pop);
    end
  end

  always_ff @(posedge clk) if (f_push) q[wp] <= f_data;

  wcst_front u_front (
    .clk(clk), .rst(rst), .in_ch(in_ch),
    .q_push(f_push), .q_data(f_data), .q_full(cnt == 2'(QDepth))
  );

  wcst_back u_back (
    .clk(clk), .rst(rst), .q_valid(cnt != '0), .q_data(q[rp]), .q_pop(b_pop),
    .rate(rate), .gain(gain), .damp(damp), .out_ch(out_ch)
  );
endmodule

### rtl/wcst_checker.sv
module wcst_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [15:0] presence,
  input logic pready
);
  a_pready: assert property (@(posedge clk) pready) else $error("pready low");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(presence)) else $error("output dropped");
  a_rst: assert property (@(posedge clk) rst |=> !out_valid) else $error("valid after reset");
  a_rdy: assert property (@(posedge clk) rst |=> in_ready || in_valid)
    else $error("input not ready after reset");
endmodule

bind weighted_centroid_spring_tracker wcst_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .presence(out_ch.presence),
  .pready(pready)
);
